>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the longest unique substring block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/lusl_pkg.sv
// Package with the field widths and constants of the longest unique substring block.
`timescale 1ns / 1ps
`default_nettype none

package lusl_pkg;

   localparam int CHAR_W      = 8;
   localparam int LEN_W       = 16;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;

   localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

   // Byte under work between the table read and the window update.
   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              first;
      logic              last;
   } item_type;

endpackage

`default_nettype wire

>>> sv/lusl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module lusl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/longest_unique_substring_length.sv
// Top level: longest repeat-free window length over a byte stream.
//
//   channel | direction | tdata                        | tlast   | tuser
//   req_    | in        | [7:0] char_code              | last    | first
//   rsp_    | out       | [15:0] window, [31:16] best  | is_last | overflow
//
// One byte is taken per cycle while no result is stalled; each byte passes the registered
// read of the last-position RAM, then the window update stage and the output register,
// with the write of one byte forwarded to the read of the next.
// Reset is synchronous and needs no clearing pass: the per-code valid bits clear at once.
// A stalled result holds the update stage, which then holds the input.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module longest_unique_substring_length #(
   parameter int POSITION_BITS = 16,
   parameter int ALPHABET_SIZE = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [lusl_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [7:0] char_code
   input  wire logic                                req_tlast,
   input  wire logic                                req_tuser,  // [0] first
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [lusl_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // [15:0] window, [31:16] best
   output logic                                     rsp_tlast,
   output logic                                     rsp_tuser   // [0] overflow
);

   localparam int ADDR_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int EXT_W  = (POSITION_BITS > lusl_pkg::LEN_W) ? POSITION_BITS : lusl_pkg::LEN_W;
   localparam int CODE_W = lusl_pkg::CHAR_W + 1;

   localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;
   localparam logic [POSITION_BITS-1:0] POS_ONE   = POSITION_BITS'(1);

   // Update stage.
   logic                   b_valid_ff, b_valid_in;
   lusl_pkg::item_type     b_item_ff,  b_item_in;

   // String state.
   logic [POSITION_BITS-1:0] left_ff, left_in;
   logic [POSITION_BITS-1:0] pos_ff,  pos_in;
   logic [POSITION_BITS-1:0] best_ff, best_in;
   logic                     ovf_ff,  ovf_in;
   logic [ALPHABET_SIZE-1:0] valid_ff, valid_in;

   // Most recent table write, for a read that raced it.
   logic                     fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]        fwd_addr_ff,  fwd_addr_in;
   logic [POSITION_BITS-1:0] fwd_data_ff,  fwd_data_in;

   // Output register.
   logic                        out_valid_ff,  out_valid_in;
   logic [lusl_pkg::LEN_W-1:0]  out_window_ff, out_window_in;
   logic [lusl_pkg::LEN_W-1:0]  out_best_ff,   out_best_in;
   logic                        out_last_ff,   out_last_in;
   logic                        out_ovf_ff,    out_ovf_in;

   logic                     req_fire;
   logic                     b_fire;
   logic [ADDR_W-1:0]        addr;
   logic                     in_alpha;
   logic [POSITION_BITS-1:0] eff_left, eff_pos, eff_best;
   logic                     eff_ovf;
   logic                     entry_valid;
   logic [POSITION_BITS-1:0] ram_rd_data;
   logic [POSITION_BITS-1:0] prev_pos;
   logic                     full;
   logic                     hit;
   logic [POSITION_BITS-1:0] new_left;
   logic [POSITION_BITS-1:0] window;
   logic [POSITION_BITS-1:0] best_next;
   logic                     ram_wr_en;

   function automatic logic [lusl_pkg::LEN_W-1:0] sat_len(input logic [POSITION_BITS-1:0] v);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(v);
      return (ext > EXT_W'(lusl_pkg::LEN_MAX)) ? lusl_pkg::LEN_MAX : ext[lusl_pkg::LEN_W-1:0];
   endfunction

   lusl_ram #(
      .WIDTH (POSITION_BITS),
      .DEPTH (ALPHABET_SIZE)
   ) u_last_pos (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr),
      .wr_data (eff_pos),
      .rd_en   (req_fire),
      .rd_addr (req_tdata[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      b_fire     = b_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready = !b_valid_ff || b_fire;
      req_fire   = req_tvalid && req_tready;

      addr     = b_item_ff.char_code[ADDR_W-1:0];
      in_alpha = ({1'b0, b_item_ff.char_code} < CODE_W'(ALPHABET_SIZE));

      // A first marker clears the string state ahead of its own byte.
      eff_left = b_item_ff.first ? '0 : left_ff;
      eff_pos  = b_item_ff.first ? '0 : pos_ff;
      eff_best = b_item_ff.first ? '0 : best_ff;
      eff_ovf  = b_item_ff.first ? 1'b0 : ovf_ff;

      entry_valid = in_alpha && !b_item_ff.first && valid_ff[addr];
      prev_pos    = (fwd_valid_ff && (fwd_addr_ff == addr)) ? fwd_data_ff : ram_rd_data;

      full      = eff_ovf || (eff_pos == POS_LIMIT);
      hit       = entry_valid && (prev_pos >= eff_left);
      new_left  = hit ? (prev_pos + POS_ONE) : eff_left;
      window    = full ? (eff_pos - eff_left) : (eff_pos - new_left + POS_ONE);
      best_next = (!full && (window > eff_best)) ? window : eff_best;
      ram_wr_en = b_fire && !full && in_alpha;

      b_valid_in = req_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_ff);
      b_item_in  = b_item_ff;
      if (req_fire) begin
         b_item_in.char_code = req_tdata[lusl_pkg::CHAR_W-1:0];
         b_item_in.first     = req_tuser;
         b_item_in.last      = req_tlast;
      end

      left_in  = left_ff;
      pos_in   = pos_ff;
      best_in  = best_ff;
      ovf_in   = ovf_ff;
      valid_in = valid_ff;
      if (b_fire) begin
         left_in = full ? eff_left : new_left;
         pos_in  = full ? eff_pos : (eff_pos + POS_ONE);
         best_in = best_next;
         ovf_in  = full;
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            valid_in[i] = (!b_item_ff.first && valid_ff[i])
                        || (!full && in_alpha && (addr == ADDR_W'(i)));
         end
      end

      fwd_valid_in = fwd_valid_ff || ram_wr_en;
      fwd_addr_in  = ram_wr_en ? addr : fwd_addr_ff;
      fwd_data_in  = ram_wr_en ? eff_pos : fwd_data_ff;

      out_valid_in  = b_fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_window_in = b_fire ? sat_len(window) : out_window_ff;
      out_best_in   = b_fire ? sat_len(best_next) : out_best_ff;
      out_last_in   = b_fire ? b_item_ff.last : out_last_ff;
      out_ovf_in    = b_fire ? full : out_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         left_ff      <= '0;
         pos_ff       <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         left_ff      <= left_in;
         pos_ff       <= pos_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         valid_ff     <= valid_in;
         fwd_valid_ff <= fwd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_item_ff     <= b_item_in;
      fwd_addr_ff   <= fwd_addr_in;
      fwd_data_ff   <= fwd_data_in;
      out_window_ff <= out_window_in;
      out_best_ff   <= out_best_in;
      out_last_ff   <= out_last_in;
      out_ovf_ff    <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_best_ff, out_window_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

   `ASSERT_IMPLY(a_stall_blocks_input, clock, reset, b_valid_ff && !b_fire, !req_tready, "update stage stalled but input still ready")
   `ASSERT_IMPLY(a_best_covers_window, clock, reset, rsp_tvalid, rsp_tdata[31:16] >= rsp_tdata[15:0], "best length below window length")
   `ASSERT_ALWAYS(a_left_not_past_pos, clock, reset, left_ff <= pos_ff, "window left edge beyond current position")

endmodule

`default_nettype wire
